// ===== rtl/core/deq_pkg.sv =====
// Types and codes shared by the double-ended queue unit.
// No dependencies.
`default_nettype none

package deq_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef struct packed {
    action_e            action;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] popped_value;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic               is_empty;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/core/double_ended_queue_unit.sv =====
// Double-ended queue of signed 32-bit words over a circular RAM.
// Depends on deq_pkg and deq_ram.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | in_data_i  (deq_pkg::in_t)
//   out     | output    | out_valid_o/out_ready_i| out_data_o (deq_pkg::out_t)
//
// A push, a rejected word, or a pop that empties the queue shows its result in
// the cycle after acceptance; the next word can be taken in that same cycle.
// A pop that leaves entries reads the new end value from the RAM in S_READ and
// takes no word there; pushes run at one per cycle while the output drains.
// Reset clears pointers, count and control; RAM contents are not cleared.
// A result waits in the output register; input is taken once it drains.
`default_nettype none

module double_ended_queue_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire deq_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output deq_pkg::out_t      out_data_o
);

  import deq_pkg::*;

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW:0]   DepthI = (IdxW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  function automatic logic [IdxW-1:0] wrap_add(logic [IdxW-1:0] a, logic [IdxW-1:0] b);
    logic [IdxW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DepthI) begin
      s = s - DepthI;
    end
    return s[IdxW-1:0];
  endfunction

  state_e             state_q, state_d;
  logic [IdxW-1:0]    head_q, head_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic signed [31:0] front_q, front_d;
  logic signed [31:0] back_q, back_d;
  logic signed [31:0] pend_q, pend_d;
  logic               rd_front_q, rd_front_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic [IdxW-1:0]    ram_raddr;
  logic [31:0]        ram_rdata;

  logic               in_fire;
  logic               emit;
  status_e            st;
  logic signed [31:0] popped;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    front_d     = front_q;
    back_d      = back_q;
    pend_d      = pend_q;
    rd_front_d  = rd_front_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_raddr   = head_q;
    emit        = 1'b0;
    st          = ST_OK;
    popped      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          emit = 1'b1;
          unique case (in_data_i.action)
            ACT_PUSH_FRONT: begin
              if (cnt_q == DepthC) begin
                st = ST_OVERFLOW;
              end else begin
                head_d    = (head_q == '0) ? LastIdx : head_q - IdxW'(1);
                ram_we    = 1'b1;
                ram_waddr = head_d;
                front_d   = in_data_i.value;
                if (cnt_q == '0) begin
                  back_d = in_data_i.value;
                end
                cnt_d = cnt_q + CntW'(1);
              end
            end
            ACT_PUSH_BACK: begin
              if (cnt_q == DepthC) begin
                st = ST_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wrap_add(head_q, cnt_q[IdxW-1:0]);
                back_d    = in_data_i.value;
                if (cnt_q == '0) begin
                  front_d = in_data_i.value;
                end
                cnt_d = cnt_q + CntW'(1);
              end
            end
            ACT_POP_FRONT: begin
              if (cnt_q == '0) begin
                st = ST_UNDERFLOW;
              end else begin
                popped = front_q;
                head_d = wrap_add(head_q, IdxW'(1));
                cnt_d  = cnt_q - CntW'(1);
                if (cnt_d != '0) begin
                  // new front comes from the RAM next cycle
                  ram_raddr  = head_d;
                  rd_front_d = 1'b1;
                  pend_d     = front_q;
                  state_d    = S_READ;
                  emit       = 1'b0;
                end
              end
            end
            ACT_POP_BACK: begin
              if (cnt_q == '0) begin
                st = ST_UNDERFLOW;
              end else begin
                popped = back_q;
                cnt_d  = cnt_q - CntW'(1);
                if (cnt_d != '0) begin
                  ram_raddr  = wrap_add(head_q, IdxW'(cnt_q - CntW'(2)));
                  rd_front_d = 1'b0;
                  pend_d     = back_q;
                  state_d    = S_READ;
                  emit       = 1'b0;
                end
              end
            end
          endcase
        end
      end
      S_READ: begin
        if (rd_front_q) begin
          front_d = ram_rdata;
        end else begin
          back_d = ram_rdata;
        end
        popped  = pend_q;
        emit    = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      out_d.status       = st;
      out_d.popped_value = popped;
      out_d.is_empty     = (cnt_d == '0);
      out_d.front_value  = (cnt_d == '0) ? '0 : front_d;
      out_d.back_value   = (cnt_d == '0) ? '0 : back_d;
      out_valid_d        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      rd_front_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      rd_front_q  <= rd_front_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  deq_ram #(
    .Width(32),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_data_i.value),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/deq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module deq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== tb/sv/double_ended_queue_unit_tb.sv =====
// Self-checking testbench for double_ended_queue_unit: directed and random push/pop
// words checked against an in-bench deque predictor. Depends on deq_pkg and the RTL.
`timescale 1ns / 100ps

module double_ended_queue_unit_tb;
  import deq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 11;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  double_ended_queue_unit #(.DEPTH(DEPTH)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Mirror of the deque contents
  logic signed [31:0] mirror_store [DEPTH];
  logic [3:0]         mirror_head;
  int                 mirror_count;

  out_t expected_results [$];
  int   error_count;
  int   cycle_count;
  int   words_sent;
  int   overflow_count;
  int   underflow_count;
  int   full_hits;
  int   results_checked;
  bit   calm_mode;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("double_ended_queue_unit test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm_mode ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    out_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result word with no prediction pending");
        error_count++;
      end else begin
        exp_w = expected_results[0];
        expected_results.delete(0);
        results_checked++;
        if (out_data_o.status !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, out_data_o.status);
          error_count++;
        end
        if (out_data_o.popped_value !== exp_w.popped_value) begin
          $error("popped_value: expected %0d, got %0d",
                 exp_w.popped_value, out_data_o.popped_value);
          error_count++;
        end
        if (out_data_o.front_value !== exp_w.front_value) begin
          $error("front_value: expected %0d, got %0d",
                 exp_w.front_value, out_data_o.front_value);
          error_count++;
        end
        if (out_data_o.back_value !== exp_w.back_value) begin
          $error("back_value: expected %0d, got %0d",
                 exp_w.back_value, out_data_o.back_value);
          error_count++;
        end
        if (out_data_o.is_empty !== exp_w.is_empty) begin
          $error("is_empty: expected %0b, got %0b", exp_w.is_empty, out_data_o.is_empty);
          error_count++;
        end
      end
    end
  end

  function automatic logic [3:0] slot_from_head(int offset);
    return 4'((int'(mirror_head) + offset) % DEPTH);
  endfunction

  // Apply one accepted word to the mirror and queue the result it should produce
  task automatic deque_predict(input in_t w);
    out_t r;
    r = '0;
    r.status = ST_OK;
    case (w.action) inside
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (mirror_count >= DEPTH) begin
          r.status = ST_OVERFLOW;
          overflow_count++;
        end else if (w.action == ACT_PUSH_FRONT) begin
          mirror_head = slot_from_head(DEPTH - 1);
          mirror_store[mirror_head] = w.value;
          mirror_count++;
        end else begin
          mirror_store[slot_from_head(mirror_count)] = w.value;
          mirror_count++;
        end
        if (mirror_count == DEPTH) full_hits++;
      end
      default: begin
        if (mirror_count == 0) begin
          r.status = ST_UNDERFLOW;
          underflow_count++;
        end else if (w.action == ACT_POP_FRONT) begin
          r.popped_value = mirror_store[mirror_head];
          mirror_head = slot_from_head(1);
          mirror_count--;
        end else begin
          r.popped_value = mirror_store[slot_from_head(mirror_count - 1)];
          mirror_count--;
        end
      end
    endcase
    if (mirror_count != 0) begin
      r.front_value = mirror_store[mirror_head];
      r.back_value  = mirror_store[slot_from_head(mirror_count - 1)];
    end
    r.is_empty = (mirror_count == 0);
    expected_results.insert(expected_results.size(), r);
  endtask

  // Present one word, hold it until accepted, then predict its result
  task automatic send_word(input action_e act, input logic signed [31:0] val);
    in_t w;
    w.action = act;
    w.value  = val;
    while (!calm_mode && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    deque_predict(w);
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic action_e pick_action(int push_pct);
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
  endfunction

  // Empty pops, two-entry round trip, fill to full, overflow, pops from full
  task automatic test_directed();
    logic signed [31:0] pattern [4];
    pattern[0] = 32'sh5555_5555;
    pattern[1] = 32'shaaaa_aaaa;
    pattern[2] = 32'sh0000_0000;
    pattern[3] = -32'sd1;
    send_word(ACT_POP_FRONT, 32'sh1234_5678);
    send_word(ACT_POP_BACK, -32'sd1);
    send_word(ACT_PUSH_FRONT, 32'sh8000_0000);
    send_word(ACT_PUSH_BACK, 32'sh7fff_ffff);
    send_word(ACT_POP_BACK, '0);
    send_word(ACT_POP_FRONT, '0);
    // head wraps below zero on the first front push
    for (int i = 0; i < DEPTH; i++)
      send_word(i % 2 ? ACT_PUSH_BACK : ACT_PUSH_FRONT, pattern[i % 4] ^ i);
    send_word(ACT_PUSH_FRONT, 32'sh7fff_ffff);
    send_word(ACT_PUSH_BACK, 32'sh8000_0000);
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_POP_BACK, '0);
  endtask

  // Bursts biased toward pushes or pops so the queue swings between empty and full
  task automatic test_random_bursts(input int n_words, input int pause_every);
    int push_pct;
    int burst_left;
    push_pct   = 50;
    burst_left = 0;
    for (int i = 0; i < n_words; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 12);
        case ($urandom_range(2))
          0:       push_pct = 20;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      burst_left--;
      send_word(pick_action(push_pct), pick_value());
      if (pause_every != 0 && i % pause_every == pause_every - 1) drain_results();
    end
  endtask

  // Full-rate traffic on both sides with no idle or stall
  task automatic test_back_to_back(input int n_words);
    calm_mode = 1'b1;
    for (int i = 0; i < n_words; i++)
      send_word(pick_action(i < n_words / 2 ? 70 : 35), pick_value());
    drain_results();
    calm_mode = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) mirror_store[i] = '0;
    mirror_head     = '0;
    mirror_count    = 0;
    error_count     = 0;
    cycle_count     = 0;
    words_sent      = 0;
    overflow_count  = 0;
    underflow_count = 0;
    full_hits       = 0;
    results_checked = 0;
    calm_mode       = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    drain_results();
    test_random_bursts(380, 0);
    test_back_to_back(120);
    test_random_bursts(130, 45);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      error_count++;
    end
    $display("Covered %0d words, %0d results checked, both ends pushed and popped.",
             words_sent, results_checked);
    $display("Queue hit full %0d times, with %0d overflows and %0d underflows.",
             full_hits, overflow_count, underflow_count);
    if (error_count == 0) begin
      $display("double_ended_queue_unit test passed");
    end else begin
      $display("double_ended_queue_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/double_ended_queue_unit.sv
tb/sv/double_ended_queue_unit_tb.sv
